### design/cvf_pkg.sv
package cvf_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               in_band;
  } out_item_t;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_UNIT_X   = 3'd3,
    CFG_UNIT_Y   = 3'd4,
    CFG_UNIT_Z   = 3'd5,
    CFG_STRENGTH = 3'd6,
    CFG_BOUND    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic valid;
    logic band;
    logic neg;
  } div_tag_t;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int UNIT_W = 18;
  localparam int BOUND_W = 31;
  localparam logic signed [UNIT_W-1:0] UNIT_Z_RESET = 18'sd65536;

  // round(2^32 / (2*pi))
  localparam logic [29:0] INV_TWO_PI = 30'd683565276;
  localparam logic [63:0] HALF_Q32 = 64'h0000_0000_8000_0000;

  localparam int DIST_W = 48;
  localparam int ROOT_W = DIST_W / 2;
  localparam int MAG_W = 56;
  localparam int FRONT_STAGES = 8;
  localparam int SQRT_BPS_DEF = 4;
  localparam int DIV_BPS_DEF = 4;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] res;
    if (v > 40'sd2147483647) begin
      res = 32'sh7fff_ffff;
    end else if (v < -40'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

### design/cvf_sqrt.sv
module cvf_sqrt #(
  parameter int NW  = 48,
  parameter int BPS = 4
) (
  input  logic              clk,
  input  logic [NW-1:0]     radicand,
  output logic [NW/2-1:0]   root
);
  localparam int RW = NW / 2;
  localparam int STG = RW / BPS;

  logic [NW-1:0] nn_r   [STG];
  logic [RW+2:0] rm_r   [STG];
  logic [RW-1:0] root_r [STG];

  for (genvar s = 0; s < STG; s++) begin : g_stage
    logic [NW-1:0] nn_i;
    logic [RW+2:0] rm_i;
    logic [RW-1:0] root_i;
    logic [NW-1:0] nn_nxt;
    logic [RW+2:0] rm_nxt;
    logic [RW-1:0] root_nxt;

    if (s == 0) begin : g_first
      assign nn_i = radicand;
      assign rm_i = '0;
      assign root_i = '0;
    end else begin : g_next
      assign nn_i = nn_r[s-1];
      assign rm_i = rm_r[s-1];
      assign root_i = root_r[s-1];
    end

    always_comb begin
      logic [RW+2:0] trial;
      nn_nxt = nn_i;
      rm_nxt = rm_i;
      root_nxt = root_i;
      for (int b = 0; b < BPS; b++) begin
        rm_nxt = {rm_nxt[RW:0], nn_nxt[NW-1 -: 2]};
        nn_nxt = {nn_nxt[NW-3:0], 2'b00};
        trial = {1'b0, root_nxt, 2'b01};
        if (rm_nxt >= trial) begin
          rm_nxt = rm_nxt - trial;
          root_nxt = {root_nxt[RW-2:0], 1'b1};
        end else begin
          root_nxt = {root_nxt[RW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      nn_r[s] <= nn_nxt;
      rm_r[s] <= rm_nxt;
      root_r[s] <= root_nxt;
    end
  end

  assign root = root_r[STG-1];

endmodule

### design/cvf_div.sv
module cvf_div #(
  parameter int DW  = 56,
  parameter int VW  = 24,
  parameter int BPS = 4,
  parameter int TW  = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [DW-1:0] num,
  input  logic [VW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic [DW-1:0] quo,
  output logic [TW-1:0] tag_out
);
  localparam int STG = DW / BPS;

  logic [DW-1:0] nn_r [STG];
  logic [VW-1:0] rm_r [STG];
  logic [DW-1:0] q_r  [STG];
  logic [VW-1:0] d_r  [STG];
  logic [TW-1:0] tg_r [STG];

  for (genvar s = 0; s < STG; s++) begin : g_stage
    logic [DW-1:0] nn_i;
    logic [VW-1:0] rm_i;
    logic [DW-1:0] q_i;
    logic [VW-1:0] d_i;
    logic [TW-1:0] tg_i;
    logic [DW-1:0] nn_nxt;
    logic [VW-1:0] rm_nxt;
    logic [DW-1:0] q_nxt;

    if (s == 0) begin : g_first
      assign nn_i = num;
      assign rm_i = '0;
      assign q_i = '0;
      assign d_i = den;
      assign tg_i = tag_in;
    end else begin : g_next
      assign nn_i = nn_r[s-1];
      assign rm_i = rm_r[s-1];
      assign q_i = q_r[s-1];
      assign d_i = d_r[s-1];
      assign tg_i = tg_r[s-1];
    end

    always_comb begin
      logic [VW:0] r;
      nn_nxt = nn_i;
      rm_nxt = rm_i;
      q_nxt = q_i;
      for (int b = 0; b < BPS; b++) begin
        r = {rm_nxt, nn_nxt[DW-1]};
        nn_nxt = {nn_nxt[DW-2:0], 1'b0};
        if (r >= {1'b0, d_i}) begin
          r = r - {1'b0, d_i};
          q_nxt = {q_nxt[DW-2:0], 1'b1};
        end else begin
          q_nxt = {q_nxt[DW-2:0], 1'b0};
        end
        rm_nxt = r[VW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      nn_r[s] <= nn_nxt;
      rm_r[s] <= rm_nxt;
      q_r[s] <= q_nxt;
      d_r[s] <= d_i;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tg_r[s] <= '0;
      end else begin
        tg_r[s] <= tg_i;
      end
    end
  end

  assign quo = q_r[STG-1];
  assign tag_out = tg_r[STG-1];

endmodule

### design/cylindrical_vortex_force.sv
// Fully pipelined: one position is taken in every cycle and busy stays low.
// The accepting edge loads the first of 29 register stages: 8 front stages, a
// 6-stage square root, a 14-stage divider and the output register, which drives
// out_valid. Throughput: one result per cycle, no stalls.
// Reset (rst_n low at a clock edge) clears all valid bits and loads the
// register defaults: unit axis along z, all other registers zero.
module cylindrical_vortex_force #(
  parameter int SQRT_BPS = cvf_pkg::SQRT_BPS_DEF,
  parameter int DIV_BPS  = cvf_pkg::DIV_BPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  cvf_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  output cvf_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [cvf_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [cvf_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import cvf_pkg::*;

  localparam int SQ_STG = ROOT_W / SQRT_BPS;
  localparam int DV_STG = MAG_W / DIV_BPS;
  localparam int LAT = FRONT_STAGES + SQ_STG + DV_STG + 1;

  logic signed [31:0]       org_r [3];
  logic signed [UNIT_W-1:0] unit_r [3];
  logic signed [31:0]       fs_r;
  logic [BOUND_W-1:0]       bound_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0] <= '0;
      org_r[1] <= '0;
      org_r[2] <= '0;
      unit_r[0] <= '0;
      unit_r[1] <= '0;
      unit_r[2] <= UNIT_Z_RESET;
      fs_r <= '0;
      bound_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_ORIGIN_X: org_r[0] <= cfg_wdata;
        CFG_ORIGIN_Y: org_r[1] <= cfg_wdata;
        CFG_ORIGIN_Z: org_r[2] <= cfg_wdata;
        CFG_UNIT_X:   unit_r[0] <= cfg_wdata[UNIT_W-1:0];
        CFG_UNIT_Y:   unit_r[1] <= cfg_wdata[UNIT_W-1:0];
        CFG_UNIT_Z:   unit_r[2] <= cfg_wdata[UNIT_W-1:0];
        CFG_STRENGTH: fs_r <= cfg_wdata;
        CFG_BOUND:    bound_r <= cfg_wdata[BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic                 vld_r [FRONT_STAGES];
  logic                 accept;
  logic signed [31:0]   pos [3];

  assign accept = start && !busy;
  assign pos[0] = in_data.pos_x;
  assign pos[1] = in_data.pos_y;
  assign pos[2] = in_data.pos_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FRONT_STAGES; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[0] <= accept;
      for (int i = 1; i < FRONT_STAGES; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  logic signed [32:0] x1_r [3];
  logic signed [50:0] xu_r [3];
  logic signed [32:0] x2_r [3];
  logic signed [36:0] t_r;
  logic signed [32:0] x3_r [3];
  logic signed [54:0] tu_r [3];
  logic signed [32:0] x4_r [3];
  logic signed [31:0] v_r [3];
  logic [63:0]        sq_r [3];
  logic signed [49:0] cpa_r [3];
  logic signed [49:0] cpb_r [3];
  logic signed [61:0] gp_r;
  logic [63:0]        dist_r;
  logic signed [26:0] c_r [3];
  logic signed [29:0] g_r;
  logic               band_r;
  logic [DIST_W-1:0]  rad_r;
  logic signed [56:0] num_r [3];
  logic signed [52:0] dot;

  assign dot = 53'(xu_r[0]) + 53'(xu_r[1]) + 53'(xu_r[2]);

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      x1_r[k] <= 33'(pos[k]) - 33'(org_r[k]);
      xu_r[k] <= 51'(x1_r[k]) * 51'(unit_r[k]);
      x2_r[k] <= x1_r[k];
      x3_r[k] <= x2_r[k];
      tu_r[k] <= 55'(t_r) * 55'(unit_r[k]);
      x4_r[k] <= x3_r[k];
      v_r[k] <= sat32(40'(x4_r[k]) - 40'($signed(tu_r[k][54:16])));
      sq_r[k] <= 64'(64'(v_r[k]) * 64'(v_r[k]));
      c_r[k] <= 27'(51'(cpa_r[k]) - 51'(cpb_r[k]) >>> 16);
      num_r[k] <= 57'(g_r) * 57'(c_r[k]);
    end
    t_r <= dot[52:16];
    cpa_r[0] <= 50'(v_r[1]) * 50'(unit_r[2]);
    cpb_r[0] <= 50'(v_r[2]) * 50'(unit_r[1]);
    cpa_r[1] <= 50'(v_r[2]) * 50'(unit_r[0]);
    cpb_r[1] <= 50'(v_r[0]) * 50'(unit_r[2]);
    cpa_r[2] <= 50'(v_r[0]) * 50'(unit_r[1]);
    cpb_r[2] <= 50'(v_r[1]) * 50'(unit_r[0]);
    gp_r <= 62'(fs_r) * $signed({32'd0, INV_TWO_PI});
    dist_r <= sq_r[0] + sq_r[1] + sq_r[2];
    g_r <= gp_r[61:32];
    band_r <= (dist_r >= HALF_Q32) && (dist_r <= {17'd0, bound_r, 16'd0});
    rad_r <= dist_r[DIST_W-1:0];
  end

  logic [ROOT_W-1:0] root;

  cvf_sqrt #(
    .NW  (DIST_W),
    .BPS (SQRT_BPS)
  ) u_sqrt (
    .clk      (clk),
    .radicand (rad_r),
    .root     (root)
  );

  logic [MAG_W-1:0] mag_dl_r [SQ_STG][3];
  logic             neg_dl_r [SQ_STG][3];
  logic             band_dl_r [SQ_STG];
  logic             vld_dl_r [SQ_STG];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      neg_dl_r[0][k] <= num_r[k][56];
      mag_dl_r[0][k] <= num_r[k][56] ? 56'(-num_r[k]) : num_r[k][MAG_W-1:0];
    end
    band_dl_r[0] <= band_r;
    for (int i = 1; i < SQ_STG; i++) begin
      mag_dl_r[i] <= mag_dl_r[i-1];
      neg_dl_r[i] <= neg_dl_r[i-1];
      band_dl_r[i] <= band_dl_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SQ_STG; i++) begin
        vld_dl_r[i] <= 1'b0;
      end
    end else begin
      vld_dl_r[0] <= vld_r[FRONT_STAGES-1];
      for (int i = 1; i < SQ_STG; i++) begin
        vld_dl_r[i] <= vld_dl_r[i-1];
      end
    end
  end

  div_tag_t         tag0_in;
  div_tag_t         tag0_out;
  logic [MAG_W-1:0] quo [3];
  logic             neg_out [3];

  assign tag0_in = '{valid: vld_dl_r[SQ_STG-1], band: band_dl_r[SQ_STG-1],
                     neg: neg_dl_r[SQ_STG-1][0]};
  assign neg_out[0] = tag0_out.neg;

  cvf_div #(
    .DW  (MAG_W),
    .VW  (ROOT_W),
    .BPS (DIV_BPS),
    .TW  ($bits(div_tag_t))
  ) u_div0 (
    .clk     (clk),
    .rst_n   (rst_n),
    .num     (mag_dl_r[SQ_STG-1][0]),
    .den     (root),
    .tag_in  (tag0_in),
    .quo     (quo[0]),
    .tag_out (tag0_out)
  );

  for (genvar k = 1; k < 3; k++) begin : g_div
    cvf_div #(
      .DW  (MAG_W),
      .VW  (ROOT_W),
      .BPS (DIV_BPS),
      .TW  (1)
    ) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .num     (mag_dl_r[SQ_STG-1][k]),
      .den     (root),
      .tag_in  (neg_dl_r[SQ_STG-1][k]),
      .quo     (quo[k]),
      .tag_out (neg_out[k])
    );
  end

  logic signed [31:0] frc [3];
  logic               out_valid_r;
  out_item_t          out_data_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!tag0_out.band) begin
        frc[k] = '0;
      end else if (neg_out[k]) begin
        frc[k] = (quo[k] > 56'h80000000) ? 32'sh8000_0000 : 32'(-quo[k]);
      end else begin
        frc[k] = (quo[k] > 56'h7fffffff) ? 32'sh7fff_ffff : quo[k][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= tag0_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.force_x <= frc[0];
    out_data_r.force_y <= frc[1];
    out_data_r.force_z <= frc[2];
    out_data_r.in_band <= tag0_out.band;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

`ifndef SYNTHESIS
  a_zero_out_of_band: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.in_band |->
      out_data.force_x == 0 && out_data.force_y == 0 && out_data.force_z == 0)
    else $error("force not zero outside the band");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result strobe without an accepted position");

  a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("accepted position produced no result");
`endif

endmodule

### bench/cylindrical_vortex_force_tb.sv
`timescale 1ns / 100ps

module cylindrical_vortex_force_tb;
  import cvf_pkg::*;

  class vortex_scoreboard;
    longint org_x, org_y, org_z;
    longint dir_x, dir_y, dir_z;
    longint strength;
    longint unsigned bound;
    out_item_t pending[$];
    int errors;

    function new();
      org_x = 0; org_y = 0; org_z = 0;
      dir_x = 0; dir_y = 0; dir_z = 65536;
      strength = 0;
      bound = 0;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] val);
      case (idx)
        CFG_ORIGIN_X: org_x = longint'(signed'(val));
        CFG_ORIGIN_Y: org_y = longint'(signed'(val));
        CFG_ORIGIN_Z: org_z = longint'(signed'(val));
        CFG_UNIT_X:   dir_x = longint'(signed'(val[17:0]));
        CFG_UNIT_Y:   dir_y = longint'(signed'(val[17:0]));
        CFG_UNIT_Z:   dir_z = longint'(signed'(val[17:0]));
        CFG_STRENGTH: strength = longint'(signed'(val));
        CFG_BOUND:    bound = longint'(val[30:0]);
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint unsigned root(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function out_item_t swirl(in_item_t p);
      out_item_t r;
      longint xx, xy, xz, t, vx, vy, vz, len, g, c0, c1, c2;
      longint unsigned d;
      logic band;
      xx = longint'(p.pos_x) - org_x;
      xy = longint'(p.pos_y) - org_y;
      xz = longint'(p.pos_z) - org_z;
      t = (xx * dir_x + xy * dir_y + xz * dir_z) >>> 16;
      vx = clamp32(xx - ((t * dir_x) >>> 16));
      vy = clamp32(xy - ((t * dir_y) >>> 16));
      vz = clamp32(xz - ((t * dir_z) >>> 16));
      d = longint'(unsigned'(vx * vx)) + longint'(unsigned'(vy * vy))
        + longint'(unsigned'(vz * vz));
      band = (d >= 64'h8000_0000) && (d <= (bound << 16));
      r = '0;
      r.in_band = band;
      if (band) begin
        len = longint'(root(d));
        g = (strength * 64'sd683565276) >>> 32;
        c0 = (vy * dir_z - vz * dir_y) >>> 16;
        c1 = (vz * dir_x - vx * dir_z) >>> 16;
        c2 = (vx * dir_y - vy * dir_x) >>> 16;
        r.force_x = 32'(clamp32((g * c0) / len));
        r.force_y = 32'(clamp32((g * c1) / len));
        r.force_z = 32'(clamp32((g * c2) / len));
      end
      return r;
    endfunction

    function void note_transfer(in_item_t p);
      pending = {pending, swirl(p)};
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = pending.pop_front();
      if (got.force_x !== want.force_x || got.force_y !== want.force_y ||
          got.force_z !== want.force_z || got.in_band !== want.in_band)
        report($sformatf("got %0d %0d %0d band %b, want %0d %0d %0d band %b",
          got.force_x, got.force_y, got.force_z, got.in_band,
          want.force_x, want.force_y, want.force_z, want.in_band));
    endtask
  endclass

  logic clk, rst_n, start, busy, out_valid, cfg_we;
  in_item_t in_data;
  out_item_t out_data;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  vortex_scoreboard sb;
  bit quiet;

  cylindrical_vortex_force dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(20 * 400000);
    $display("cylindrical_vortex_force_tb failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_transfer(in_data);
      if (out_valid) sb.check_result(out_data);
    end
  end

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we <= 1'b0;
  endtask

  task automatic setup(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                       logic [31:0] ux, logic [31:0] uy, logic [31:0] uz,
                       logic [31:0] s, logic [31:0] b);
    drain();
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_UNIT_X, ux);
    write_reg(CFG_UNIT_Y, uy);
    write_reg(CFG_UNIT_Z, uz);
    write_reg(CFG_STRENGTH, s);
    write_reg(CFG_BOUND, b);
  endtask

  task automatic send(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    start <= 1'b1;
    in_data <= '{pos_x: px, pos_y: py, pos_z: pz};
    @(posedge clk);
    while (busy) @(posedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] near(longint base, int span);
    longint v;
    v = base + longint'($signed($urandom_range(0, 2 * span))) - span;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return 32'(v);
  endfunction

  function automatic logic [31:0] pick_unit(int k);
    case ($urandom_range(0, 3))
      0: return (k == 2) ? 32'd65536 : 32'd0;
      1: return (k == 0) ? -32'sd65536 : 32'd0;
      2: return 32'($signed($urandom_range(0, 131072)) - 65536);
      default: return (k == 2) ? 32'd0 : 32'd46341;
    endcase
  endfunction

  initial begin
    logic [31:0] ox, oy, oz, ux, uy, uz, s, b;
    int span;
    sb = new();
    rst_n = 0; start = 0; in_data = '0; cfg_we = 0; cfg_idx = '0; cfg_wdata = '0;
    quiet = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(32'd65536, 32'd0, 32'd0);
    send(32'h7fff_ffff, 32'h8000_0000, 32'd5);
    start <= 1'b0;

    setup(0, 0, 0, 0, 0, 32'd65536, 32'd65536, 32'd6553600);
    send(32'd65536, 32'd0, 32'd12345);
    send(32'd0, 32'd65536, -32'sd99999);
    send(32'd46341, 32'd0, 32'd0);
    send(32'd46340, 32'd0, 32'd0);
    send(32'd655360, 32'd0, 32'd0);
    send(32'd655361, 32'd0, 32'd0);
    send(32'd0, 32'd0, 32'h7fff_ffff);
    send(32'h7fff_ffff, 32'h7fff_ffff, 32'd0);
    send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send(-32'sd300000, 32'd200000, 32'd0);
    start <= 1'b0;

    setup(32'h8000_0000, 32'h7fff_ffff, 0, 32'd65536, 32'd65536, 0,
          32'h7fff_ffff, 32'h7fff_ffff);
    send(32'h7fff_ffff, 32'h8000_0000, 32'd0);
    send(32'h8000_0000, 32'h7fff_ffff, 32'd70000);
    send(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send(32'h0, 32'h0, 32'h8000_0000);
    start <= 1'b0;

    setup(0, 0, 0, -32'sd65536, 0, 0, 32'h8000_0000, 32'h7fff_ffff);
    send(32'd0, 32'd65536, 32'd131072);
    send(32'd5, 32'h8000_0000, 32'h7fff_ffff);
    send(32'd0, 32'd0, 32'd0);
    start <= 1'b0;

    for (int ph = 0; ph < 9; ph++) begin
      ox = ($urandom_range(0, 2) == 0) ? $urandom() : near(0, 1 << 22);
      oy = ($urandom_range(0, 2) == 0) ? $urandom() : near(0, 1 << 22);
      oz = $urandom();
      ux = pick_unit(0); uy = pick_unit(1); uz = pick_unit(2);
      s = $urandom();
      case ($urandom_range(0, 2))
        0: b = $urandom() & 32'h7fff_ffff;
        1: b = 32'h7fff_ffff;
        default: b = $urandom_range(1 << 15, 1 << 26);
      endcase
      setup(ox, oy, oz, ux, uy, uz, s, b);
      if (ph >= 7) quiet = 1;
      span = (ph % 2) ? (1 << 20) : (1 << 24);
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(0, 3) == 0)
          send($urandom(), $urandom(), $urandom());
        else
          send(near(longint'($signed(ox)), span), near(longint'($signed(oy)), span),
               near(longint'($signed(oz)), span));
      end
      start <= 1'b0;
    end

    drain();
    if (sb.pending.size() != 0) sb.report("results missing at end");
    if (sb.errors == 0) begin
      $display("cylindrical_vortex_force_tb passed");
    end else begin
      $display("cylindrical_vortex_force_tb failed");
    end
    $finish;
  end
endmodule
